// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LPDF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpdf assertion failed");

// Expression must never be true outside reset.
`define LPDF_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lpdf forbidden condition seen");

`endif

// File: rtl/core/lpdf_pkg.sv
package lpdf_pkg;

  // Widest line-start buffer the design supports.
  localparam int MAX_PATTERN_LIMIT = 32;
  // Result position within one transaction: held bytes plus up to two tail bytes.
  localparam int POS_W = $clog2(MAX_PATTERN_LIMIT + 3);

  localparam int PATTERN_W = 64;
  localparam int LENGTH_W  = 4;
  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 4'd1;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [1:0] MODE_COLLECT = 2'd0;
  localparam logic [1:0] MODE_PASS    = 2'd1;
  localparam logic [1:0] MODE_SKIP    = 2'd2;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic last;
    pos_t pos;
  } ctl_cmd_t;

  typedef struct packed {
    pos_t       flush_n;
    logic [1:0] tail_n;
    logic       out_free;
  } dp_status_t;

endpackage

// File: rtl/core/lpdf_datapath.sv
module lpdf_datapath #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [7:0]                            in_byte,
  input  logic                                  in_end_of_input,
  input  logic                                  cfg_we,
  input  logic [lpdf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lpdf_pkg::PATTERN_W-1:0]        cfg_data,
  input  lpdf_pkg::ctl_cmd_t                    cmd,
  output lpdf_pkg::dp_status_t                  status,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [7:0]                            out_byte,
  output logic                                  out_last_of_run
);
  import lpdf_pkg::*;

  localparam int CW        = $clog2(MAX_PATTERN + 1);
  localparam int IW        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_BYTES = PATTERN_W / 8;

  logic [PATTERN_W-1:0] pattern_r;
  logic [LENGTH_W-1:0]  length_r;
  logic [7:0]           held_r [MAX_PATTERN];
  logic [CW-1:0]        count_r, count_nxt;
  logic [1:0]           mode_r, mode_nxt;
  pos_t                 flush_r, flush_nxt;
  logic [1:0]           tail_r, tail_nxt;
  logic [7:0]           tail_byte_r, tail_byte_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  logic [CW-1:0]          len_eff;
  logic [CW-1:0]          count_after;
  logic                   full;
  logic                   hold_we;
  logic                   match;
  logic                   is_nl;
  logic [1:0]             mode_in;
  logic [7:0]             byte_sel;
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] in_use;

  // Length zero counts as one; saturate at the buffer depth.
  always_comb begin
    if (length_r == '0) begin
      len_eff = CW'(1);
    end else if (int'(length_r) > MAX_PATTERN) begin
      len_eff = CW'(MAX_PATTERN);
    end else begin
      len_eff = CW'(length_r);
    end
  end

  assign full        = (int'(count_r) >= MAX_PATTERN);
  assign count_after = full ? count_r : count_r + CW'(1);

  // Compare the line start, with the incoming byte standing in its slot.
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cmp
    logic [7:0] pat_byte;
    logic [7:0] cur_byte;
    if (g < PAT_BYTES) begin : g_pat
      assign pat_byte = pattern_r[8*g +: 8];
    end else begin : g_zero
      assign pat_byte = 8'h00;
    end
    assign cur_byte  = (!full && (count_r == CW'(g))) ? in_byte : held_r[g];
    assign eq[g]     = (cur_byte == pat_byte);
    assign in_use[g] = (CW'(g) < len_eff);
  end

  assign match = &(eq | ~in_use);
  assign is_nl = (in_byte == NEWLINE_BYTE);

  always_comb begin
    mode_in = ((mode_r == MODE_PASS) || (mode_r == MODE_SKIP)) ? mode_r : MODE_COLLECT;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    flush_nxt     = flush_r;
    tail_nxt      = tail_r;
    tail_byte_nxt = tail_byte_r;
    hold_we       = 1'b0;
    if (cmd.accept) begin
      flush_nxt     = '0;
      tail_nxt      = 2'd0;
      tail_byte_nxt = in_end_of_input ? NEWLINE_BYTE : in_byte;
      if (in_end_of_input) begin
        if (mode_in == MODE_COLLECT) begin
          flush_nxt = POS_W'(count_r);
        end
        // passing mode closes the open line and the stream
        tail_nxt  = (mode_in == MODE_PASS) ? 2'd2 : 2'd1;
        count_nxt = '0;
        mode_nxt  = MODE_COLLECT;
      end else begin
        case (mode_in)
          MODE_PASS: begin
            tail_nxt = 2'd1;
            if (is_nl) begin
              mode_nxt = MODE_COLLECT;
            end
          end
          MODE_SKIP: begin
            if (is_nl) begin
              mode_nxt = MODE_COLLECT;
            end
          end
          default: begin
            if (is_nl) begin
              flush_nxt = POS_W'(count_r);
              tail_nxt  = 2'd1;
              count_nxt = '0;
              mode_nxt  = MODE_COLLECT;
            end else begin
              hold_we = !full;
              if (count_after >= len_eff) begin
                count_nxt = '0;
                if (match) begin
                  mode_nxt = MODE_SKIP;
                end else begin
                  flush_nxt = POS_W'(count_after);
                  mode_nxt  = MODE_PASS;
                end
              end else begin
                count_nxt = count_after;
                mode_nxt  = MODE_COLLECT;
              end
            end
          end
        endcase
      end
    end
  end

  assign byte_sel = (cmd.pos < flush_r) ? held_r[cmd.pos[IW-1:0]] : tail_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= '0;
      length_r    <= LENGTH_W'(1);
      count_r     <= '0;
      mode_r      <= MODE_COLLECT;
      flush_r     <= '0;
      tail_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_BYTES:  pattern_r <= cfg_data;
          REG_PATTERN_LENGTH: length_r  <= cfg_data[LENGTH_W-1:0];
          default: ;
        endcase
      end
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
      flush_r <= flush_nxt;
      tail_r  <= tail_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tail_byte_r <= tail_byte_nxt;
    if (hold_we) begin
      held_r[count_r[IW-1:0]] <= in_byte;
    end
    if (cmd.load) begin
      out_byte_r <= byte_sel;
      out_last_r <= cmd.last;
    end
  end

  assign status.flush_n  = flush_r;
  assign status.tail_n   = tail_r;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: rtl/core/lpdf_ctrl.sv
module lpdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpdf_pkg::dp_status_t status,
  output lpdf_pkg::ctl_cmd_t   cmd
);
  import lpdf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;
  pos_t pos_r, pos_nxt;
  pos_t total;

  assign total = status.flush_n + POS_W'(status.tail_n);

  always_comb begin
    cmd       = '0;
    cmd.pos   = pos_r;
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          pos_nxt    = '0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (total == '0) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.load = 1'b1;
          cmd.last = (pos_r == total - POS_W'(1));
          if (cmd.last) begin
            pos_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// File: rtl/core/line_prefix_drop_filter.sv
// Line prefix drop filter: drops text lines that start with a programmed pattern.
// Acceptance moves the controller to its emit state, which loads the results;
// no new transaction is accepted until the last is loaded. Results leave one per cycle
//   unless the output stalls, via the single held-byte read port and the output register.
// Reset (rst_n low, synchronous): line state to start of line, pattern 0, length 1.
`include "assert_macros.svh"

module line_prefix_drop_filter #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_byte,
  input  logic                               in_end_of_input,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte,
  output logic                               out_last_of_run,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lpdf_pkg::PATTERN_W-1:0]     cfg_data
);
  import lpdf_pkg::*;

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;
  logic       cfg_we;
  logic       in_fire;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && !in_stall;

  lpdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (ctl_cmd)
  );

  lpdf_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (ctl_cmd),
    .status          (dp_status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // hold off the next transaction while one is being emitted
  `LPDF_ASSERT(a_accept_then_stall, clk, rst_n, ctl_cmd.accept |=> in_stall)
  // end of stream always produces at least one newline
  `LPDF_ASSERT(a_end_has_tail, clk, rst_n, (in_fire && in_end_of_input) |=> (dp_status.tail_n != 2'd0))
  `LPDF_NEVER(a_load_into_busy, clk, rst_n, ctl_cmd.load && !dp_status.out_free)

endmodule

// File: sim/line_prefix_drop_filter_tb.sv
module line_prefix_drop_filter_tb;
  import lpdf_pkg::*;

  localparam int LINE_START_MAX = 8;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_PATTERN_LENGTH + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_MAX = '1;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_byte_t;

  class line_filter_scoreboard;
    logic [PATTERN_W-1:0] pattern;
    logic [LENGTH_W-1:0]  length_reg;
    logic [7:0]           held [LINE_START_MAX];
    int unsigned          held_n;
    logic [1:0]           mode;
    line_byte_t           run_out[$];
    line_byte_t           expected_out[$];
    int                   errors;

    function new();
      pattern = '0;
      length_reg = 1;
      held_n = 0;
      mode = MODE_COLLECT;
      errors = 0;
    endfunction

    function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [PATTERN_W-1:0] value);
      if (idx == REG_PATTERN_BYTES) begin
        pattern = value;
      end else if (idx == REG_PATTERN_LENGTH) begin
        length_reg = value[LENGTH_W-1:0];
      end
    endfunction

    function int unsigned active_length();
      int unsigned len;
      len = length_reg;
      if (len == 0) len = 1;
      if (len > LINE_START_MAX) len = LINE_START_MAX;
      return len;
    endfunction

    function logic [7:0] pattern_at(int unsigned i);
      if (i >= 8) return 8'h00;
      return pattern[8*i +: 8];
    endfunction

    function void emit(logic [7:0] ch);
      run_out.push_back('{ch, 1'b0});
    endfunction

    function void flush_held();
      for (int i = 0; i < held_n; i++) emit(held[i]);
      held_n = 0;
    endfunction

    // Work out the bytes one accepted input transaction releases.
    function void predict_line_output(logic [7:0] ch, logic fin);
      int unsigned len;
      bit same;
      run_out.delete();
      if (fin) begin
        if (mode == MODE_PASS) begin
          emit(NEWLINE_BYTE);
        end else if (mode == MODE_COLLECT) begin
          flush_held();
        end
        emit(NEWLINE_BYTE);
        held_n = 0;
        mode = MODE_COLLECT;
      end else if (mode == MODE_PASS) begin
        emit(ch);
        if (ch == NEWLINE_BYTE) mode = MODE_COLLECT;
      end else if (mode == MODE_SKIP) begin
        if (ch == NEWLINE_BYTE) mode = MODE_COLLECT;
      end else if (ch == NEWLINE_BYTE) begin
        flush_held();
        emit(NEWLINE_BYTE);
      end else begin
        len = active_length();
        if (held_n < LINE_START_MAX) begin
          held[held_n] = ch;
          held_n++;
        end
        if (held_n >= len) begin
          same = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (held[i] != pattern_at(i)) same = 1'b0;
          end
          if (same) begin
            held_n = 0;
            mode = MODE_SKIP;
          end else begin
            flush_held();
            mode = MODE_PASS;
          end
        end
      end
      if (run_out.size() > 0) run_out[run_out.size()-1].last = 1'b1;
      foreach (run_out[i]) expected_out.push_back(run_out[i]);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task match_output(logic [7:0] ch, logic last);
      line_byte_t want;
      if (expected_out.size() == 0) begin
        report($sformatf("unexpected output byte 0x%02h last %0b", ch, last));
        return;
      end
      want = expected_out.pop_front();
      if (ch !== want.ch) begin
        report($sformatf("out_byte 0x%02h, expected 0x%02h", ch, want.ch));
      end
      if (last !== want.last) begin
        report($sformatf("out_last_of_run %0b, expected %0b (byte 0x%02h)",
                         last, want.last, want.ch));
      end
    endtask

    task check_drained();
      if (expected_out.size() != 0) begin
        report($sformatf("%0d expected bytes never arrived", expected_out.size()));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_byte;
  logic                   in_end_of_input;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             out_byte;
  logic                   out_last_of_run;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [PATTERN_W-1:0]   cfg_data;

  line_filter_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;
  int items_sent = 0;

  line_prefix_drop_filter #(
    .MAX_PATTERN(LINE_START_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #4_000_000;
    $display("line_prefix_drop_filter_tb: errors");
    $finish;
  end

  // Result side: random stall before each result byte, one long hold on request.
  initial begin
    int unsigned wait_n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      wait_n = no_idle ? 0 : $urandom_range(0, 9);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_n = LONG_HOLD_CYCLES;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.match_output(out_byte, out_last_of_run);
    end
  end

  function automatic logic [PATTERN_W-1:0] text_pattern(string s);
    logic [PATTERN_W-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] ch;
    do begin
      if ($urandom_range(0, 3) == 0) ch = 8'($urandom_range(0, 255));
      else ch = 8'($urandom_range(8'h61, 8'h66));
    end while (ch == NEWLINE_BYTE);
    return ch;
  endfunction

  function automatic logic [PATTERN_W-1:0] random_pattern();
    logic [PATTERN_W-1:0] v;
    int unsigned r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) v[8*i +: 8] = NEWLINE_BYTE;
      else if (r < 3) v[8*i +: 8] = 8'($urandom_range(0, 255));
      else v[8*i +: 8] = 8'($urandom_range(8'h61, 8'h66));
    end
    return v;
  endfunction

  task automatic send_item(input logic [7:0] ch, input logic fin);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= ch;
    in_end_of_input <= fin;
    do @(posedge clk); while (in_stall);
    sb.predict_line_output(ch, fin);
    items_sent++;
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Hold the input, let every expected byte drain, then give the block time to finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [PATTERN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.apply_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_random_line();
    int unsigned plen, k, kind;
    logic [7:0] ch;
    plen = sb.active_length();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      send_end();
      return;
    end
    if (kind == 8) begin
      repeat ($urandom_range(0, 10)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // full prefix, prefix broken by one byte, or line shorter than the prefix
      k = (kind <= 3) ? plen : $urandom_range(0, plen - 1);
      for (int i = 0; i < k; i++) send_item(sb.pattern_at(i), 1'b0);
      if (kind == 4 || kind == 5) begin
        do ch = text_byte(); while (ch == sb.pattern_at(k));
        send_item(ch, 1'b0);
      end
      if (kind != 6 && kind != 7) begin
        repeat ($urandom_range(0, 6)) send_item(text_byte(), 1'b0);
      end
    end
    send_item(NEWLINE_BYTE, 1'b0);
  endtask

  initial begin
    logic [PATTERN_W-1:0] len_word;
    int unsigned sel, phase, random_goal;
    in_valid <= 1'b0;
    in_byte <= '0;
    in_end_of_input <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pattern: one zero byte
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_end();
    wait_idle();

    // length above the buffer saturates; end mid-collect flushes the most bytes
    cfg_write(REG_PATTERN_BYTES, text_pattern("ABCDEFGH"));
    cfg_write(REG_PATTERN_LENGTH, 64'd15);
    send_text("ABCDEFG");
    send_end();
    wait_idle();

    // newline in the pattern never matches; zero length acts as one
    cfg_write(REG_PATTERN_BYTES, 64'(NEWLINE_BYTE));
    cfg_write(REG_PATTERN_LENGTH, 64'd0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_end();
    wait_idle();

    cfg_write(REG_PATTERN_BYTES, text_pattern("pqrs"));
    cfg_write(REG_PATTERN_LENGTH, 64'd2);
    send_text("pq");
    send_end();
    send_item("z", 1'b0);
    send_end();
    wait_idle();

    // shorten the prefix while bytes are held mid-line
    cfg_write(REG_PATTERN_LENGTH, 64'd4);
    send_text("pqr");
    wait_idle();
    cfg_write(REG_PATTERN_LENGTH, 64'd2);
    send_item("t", 1'b0);
    send_end();

    random_goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_goal) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 7);
      len_word = {$urandom, $urandom};
      case (sel)
        0: len_word[LENGTH_W-1:0] = 4'd0;
        1: len_word[LENGTH_W-1:0] = 4'd1;
        2: len_word[LENGTH_W-1:0] = 4'(LINE_START_MAX);
        3: len_word[LENGTH_W-1:0] = 4'($urandom_range(LINE_START_MAX + 1, 15));
        default: len_word[LENGTH_W-1:0] = 4'($urandom_range(1, LINE_START_MAX));
      endcase
      if (phase == 0) begin
        cfg_write(REG_PATTERN_BYTES, '1);
      end else if (phase == 1) begin
        cfg_write(REG_PATTERN_BYTES, '0);
      end else begin
        cfg_write(REG_PATTERN_BYTES, random_pattern());
      end
      cfg_write(REG_PATTERN_LENGTH, len_word);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(4'($urandom_range(REG_UNUSED_FIRST, CFG_INDEX_MAX)), {$urandom, $urandom});
      end
      if (phase == 2) begin
        no_idle = 1'b1;
        hold_off_req = 1'b1;
      end
      repeat ($urandom_range(3, 10)) send_random_line();
      // leave part of a line start held across the next register change
      for (int i = $urandom_range(0, 3); i > 0; i--) send_item(sb.pattern_at(i - 1), 1'b0);
      phase++;
    end

    wait_idle();
    no_idle = 1'b0;
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("line_prefix_drop_filter_tb: clean");
    end else begin
      $display("line_prefix_drop_filter_tb: errors");
    end
    $finish;
  end

endmodule
